// ===== rtl/pu_pkg.sv =====
// Shared constants and factorial table for the permutation unranking block.
`default_nettype none

package pu_pkg;

  localparam int ORDER_W   = 4;
  localparam int INDEX_W   = 30;
  localparam int REM_W     = 29;
  localparam int SYM_W     = 4;
  localparam int MAX_ORDER_DEF = 12;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd10;

  // n! for n = 0..12, zero for codes beyond the table
  function automatic logic [REM_W-1:0] fact(input logic [ORDER_W-1:0] n);
    logic [REM_W-1:0] f;
    case (n)
      4'd0:    f = 29'd1;
      4'd1:    f = 29'd1;
      4'd2:    f = 29'd2;
      4'd3:    f = 29'd6;
      4'd4:    f = 29'd24;
      4'd5:    f = 29'd120;
      4'd6:    f = 29'd720;
      4'd7:    f = 29'd5040;
      4'd8:    f = 29'd40320;
      4'd9:    f = 29'd362880;
      4'd10:   f = 29'd3628800;
      4'd11:   f = 29'd39916800;
      4'd12:   f = 29'd479001600;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/permutation_unrank.sv =====
// Top level: lexicographic permutation unranking, one result per position.
//
//   channel | ports                                        | dir
//   --------+----------------------------------------------+-----
//   input   | in_valid, in_ready, in_perm_index            | in
//   result  | out_valid, out_ready, out_position,          | out
//           | out_symbol, out_blank, out_last              |
//   config  | cfg_we, cfg_wdata (order)                    | in
//
// One shared compare/subtract unit extracts each factorial digit by repeated
// subtraction, then presents the position on the result channel; blank rows
// skip the subtraction.
// The input is taken only when idle; a stalled result holds the sequencer.
// Synchronous active-low reset returns order to 10 and the block to idle.
`default_nettype none

module permutation_unrank #(
  parameter int MAX_ORDER = pu_pkg::MAX_ORDER_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [pu_pkg::INDEX_W-1:0] in_perm_index,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [pu_pkg::ORDER_W-1:0]       out_position,
  output logic [pu_pkg::SYM_W-1:0]         out_symbol,
  output logic                             out_blank,
  output logic                             out_last,
  input  wire logic                        cfg_we,
  input  wire logic [pu_pkg::ORDER_W-1:0]  cfg_wdata
);
  import pu_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} state_t;

  state_t               state_r;
  logic [ORDER_W-1:0]   order_r;
  logic [ORDER_W-1:0]   n_r;
  logic [ORDER_W-1:0]   pos_r;
  logic [SYM_W-1:0]     k_r;
  logic [REM_W-1:0]     rem_r;
  logic                 blank_r;
  logic [MAX_ORDER-1:0] used_r;

  logic [ORDER_W-1:0]   n_eff;
  logic [REM_W-1:0]     divisor;
  logic [SYM_W-1:0]     sel_sym;
  logic [MAX_ORDER-1:0] sel_pick;
  logic                 in_xfer;
  logic                 is_last;

  always_comb begin
    n_eff = order_r;
    if (order_r == '0) begin
      n_eff = ORDER_W'(1);
    end else if (order_r > ORDER_W'(MAX_ORDER)) begin
      n_eff = ORDER_W'(MAX_ORDER);
    end
  end

  assign divisor  = fact(n_r - pos_r - ORDER_W'(1));
  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign is_last  = (pos_r == n_r - ORDER_W'(1));

  pu_select #(.MAX_ORDER(MAX_ORDER)) u_select (
    .used (used_r),
    .k    (k_r),
    .sym  (sel_sym),
    .pick (sel_pick)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_RESET;
    end else if (cfg_we) begin
      order_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      used_r    <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            n_r     <= n_eff;
            pos_r   <= '0;
            k_r     <= '0;
            rem_r   <= in_perm_index[REM_W-1:0];
            blank_r <= in_perm_index[INDEX_W-1] ||
                       (in_perm_index[REM_W-1:0] >= fact(n_eff));
            used_r  <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (!blank_r && (rem_r >= divisor)) begin
            rem_r <= rem_r - divisor;
            k_r   <= k_r + SYM_W'(1);
          end else begin
            out_position <= pos_r;
            out_symbol   <= blank_r ? '0 : sel_sym;
            out_blank    <= blank_r;
            out_last     <= is_last;
            out_valid    <= 1'b1;
            if (!blank_r) begin
              used_r <= used_r | sel_pick;
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              state_r <= S_IDLE;
            end else begin
              pos_r   <= pos_r + ORDER_W'(1);
              k_r     <= '0;
              state_r <= S_DIV;
            end
          end
        end
        default: begin
          state_r   <= S_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pu_select.sv =====
// Picks the k-th free symbol (ascending) from a used-symbol mask.
`default_nettype none

module pu_select #(
  parameter int MAX_ORDER = pu_pkg::MAX_ORDER_DEF
) (
  input  wire logic [MAX_ORDER-1:0]    used,
  input  wire logic [pu_pkg::SYM_W-1:0] k,
  output logic      [pu_pkg::SYM_W-1:0] sym,
  output logic      [MAX_ORDER-1:0]    pick
);
  import pu_pkg::*;

  logic [MAX_ORDER-1:0] free;

  assign free = ~used;

  // each candidate checks independently how many free symbols sit below it
  always_comb begin
    logic [MAX_ORDER-1:0] below;
    sym  = '0;
    pick = '0;
    for (int s = 0; s < MAX_ORDER; s++) begin
      below = (MAX_ORDER'(1) << s) - MAX_ORDER'(1);
      if (free[s] && ($countones(free & below) == int'(k))) begin
        sym     = SYM_W'(s);
        pick[s] = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/permutation_unrank_tb.sv =====
// Self-checking testbench for permutation_unrank: rank-to-permutation scoreboard plus stimulus.
`timescale 1ns / 100ps

typedef struct packed {
  logic [pu_pkg::ORDER_W-1:0] position;
  logic [pu_pkg::SYM_W-1:0]   symbol;
  logic                       blank;
  logic                       last;
} perm_elem_t;

function automatic int unsigned factorial_of(input int unsigned n);
  int unsigned f;
  f = 1;
  for (int unsigned j = 2; j <= n; j++) f = f * j;
  return f;
endfunction

// register code 0 acts as 1, codes past 12 saturate
function automatic int unsigned effective_order(input logic [pu_pkg::ORDER_W-1:0] order_reg);
  int unsigned n;
  n = order_reg;
  if (n < 1) n = 1;
  if (n > 12) n = 12;
  return n;
endfunction

class unrank_scoreboard;
  perm_elem_t expected_q[$];
  int faults;

  function new();
    faults = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void note_fault(input string msg);
    faults++;
    if (faults <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // expand one accepted rank into its row of elements
  function void note_index(input logic [pu_pkg::ORDER_W-1:0] order_reg,
                           input logic signed [pu_pkg::INDEX_W-1:0] idx);
    int unsigned n, rem, div, k, seen, s, i;
    logic [11:0] taken;
    logic [pu_pkg::SYM_W-1:0] sym;
    bit row_blank, found;
    perm_elem_t e;
    n = effective_order(order_reg);
    rem = 32'(idx[pu_pkg::INDEX_W-2:0]);
    row_blank = idx[pu_pkg::INDEX_W-1] || (rem >= factorial_of(n));
    taken = '0;
    for (i = 0; i < n; i++) begin
      sym = '0;
      if (!row_blank) begin
        div = factorial_of(n - 1 - i);
        k = rem / div;
        rem = rem % div;
        seen = 0;
        found = 1'b0;
        // k-th symbol not yet placed, ascending
        for (s = 0; s < n; s++) begin
          if (!found && !taken[s]) begin
            if (seen == k) begin
              sym = 4'(s);
              taken[s] = 1'b1;
              found = 1'b1;
            end
            seen++;
          end
        end
      end
      e.position = 4'(i);
      e.symbol = sym;
      e.blank = row_blank;
      e.last = (i == n - 1);
      expected_q.push_back(e);
    end
  endfunction

  function void check_element(input logic [pu_pkg::ORDER_W-1:0] pos,
                              input logic [pu_pkg::SYM_W-1:0] sym,
                              input logic blank, input logic last);
    perm_elem_t e;
    if (expected_q.size() == 0) begin
      note_fault($sformatf("unexpected result pos=%0d sym=%0d blank=%b last=%b",
                           pos, sym, blank, last));
      return;
    end
    e = expected_q.pop_front();
    if (e.position !== pos || e.symbol !== sym || e.blank !== blank || e.last !== last)
      note_fault($sformatf("mismatch exp pos=%0d sym=%0d blank=%b last=%b, got pos=%0d sym=%0d blank=%b last=%b",
                           e.position, e.symbol, e.blank, e.last, pos, sym, blank, last));
  endfunction
endclass

module permutation_unrank_tb;

  localparam logic [pu_pkg::ORDER_W-1:0] ORDER_PLAN [0:15] = '{
    4'd1, 4'd12, 4'd0, 4'd15, 4'd2, 4'd3, 4'd4, 4'd5,
    4'd6, 4'd7, 4'd8, 4'd9, 4'd11, 4'd13, 4'd14, 4'd10
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [pu_pkg::INDEX_W-1:0] in_perm_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [pu_pkg::ORDER_W-1:0] out_position;
  logic [pu_pkg::SYM_W-1:0] out_symbol;
  logic out_blank;
  logic out_last;
  logic cfg_we = 1'b0;
  logic [pu_pkg::ORDER_W-1:0] cfg_wdata = '0;

  logic [pu_pkg::ORDER_W-1:0] cur_order = pu_pkg::ORDER_RESET;
  bit idle_on = 1'b1;
  unrank_scoreboard sb = new();

  permutation_unrank dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_perm_index(in_perm_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_position(out_position),
    .out_symbol(out_symbol),
    .out_blank(out_blank),
    .out_last(out_last),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_index(cur_order, in_perm_index);
    if (rst_n && out_valid && out_ready)
      sb.check_element(out_position, out_symbol, out_blank, out_last);
  end

  // result side back-pressure
  initial begin
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  task automatic push_index(input logic signed [pu_pkg::INDEX_W-1:0] idx);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_perm_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold off the sender until every pending element has been checked
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    // let the sequencer settle back to idle
    repeat (2) @(posedge clk);
  endtask

  task automatic write_order(input logic [pu_pkg::ORDER_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_order = value;
  endtask

  function automatic logic [pu_pkg::INDEX_W-1:0] pick_index(input logic [pu_pkg::ORDER_W-1:0] ord);
    int unsigned lim;
    lim = factorial_of(effective_order(ord));
    case ($urandom_range(0, 9))
      0: return {1'b1, 29'($urandom)};
      1: return 30'($urandom);
      2: return 30'(lim + $urandom_range(0, 3));
      3: return 30'(lim - 1);
      default: return 30'($urandom_range(0, lim - 1));
    endcase
  endfunction

  task automatic random_run(input int count);
    repeat (count) push_index(pick_index(cur_order));
  endtask

  initial begin
    int unsigned p;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset order of 10: boundaries of 10!, sign extremes, 12! - 1
    push_index(-30'sd1);
    push_index(30'sd0);
    push_index(30'sd1);
    push_index(30'sd3628799);
    push_index(30'sd3628800);
    push_index(30'sh1FFFFFFF);
    push_index(30'sh20000000);
    push_index(30'sd479001599);
    random_run(40);

    for (p = 0; p < 16; p++) begin
      drain_results();
      idle_on = (p >= 14) ? 1'b0 : ($urandom_range(0, 3) != 0);
      write_order(ORDER_PLAN[p]);
      case (ORDER_PLAN[p])
        4'd1: begin
          push_index(-30'sd1);
          push_index(30'sd0);
          push_index(30'sd1);
        end
        4'd12: begin
          push_index(30'sd0);
          push_index(30'sd479001599);
          push_index(30'sd479001600);
        end
        4'd0: begin
          push_index(30'sd0);
          push_index(30'sd1);
        end
        4'd15: begin
          push_index(30'sd479001599);
          push_index(30'sd479001600);
        end
        default: ;
      endcase
      random_run(12);
      if (p == 5) drain_results();
      random_run(13);
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (120) @(posedge clk);
    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
